// ===== rtl/vnp_pkg.sv =====
// ----------------------------------------------------------------------------
// vnp_pkg
// Shared widths, constants and stage payload types for the 3D vector
// normalise / project pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vnp_pkg;

  // component format
  localparam int COMP_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CW         = COMP_WIDTH;
  localparam int EPS_W      = 16;

  // squared length, accumulator and rescaled magnitude widths
  localparam int SQ_W  = 2 * CW;
  localparam int ACC_W = 64;
  localparam int RM_W  = ACC_W - FRAC_BITS;

  // divider widths: numerator and quotient bits
  localparam int NUM_W = CW + FRAC_BITS;
  localparam int QW    = FRAC_BITS + 1;

  // split point of the wide dot-product scale multiply
  localparam int LO_W    = 32;
  localparam int HI_KEEP = ACC_W - LO_W;

  // stage counts
  localparam int PROJ_LAT = 9;
  localparam int LATENCY  = 5 + CW + 1 + QW + 1 + PROJ_LAT + 1;

  // constants
  localparam logic [EPS_W-1:0] EPS_RESET  = EPS_W'(7);
  localparam logic [SQ_W-1:0]  ONE_SQ     = SQ_W'(1) << (2 * FRAC_BITS);
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [RM_W-1:0]  NEG_LIM    = RM_W'(1) << (CW - 1);
  localparam logic [RM_W-1:0]  POS_LIM    = (RM_W'(1) << (CW - 1)) - RM_W'(1);
  localparam logic [CW-1:0]    COMP_MIN   = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [CW-1:0]    COMP_MAX   = {1'b0, {(CW - 1){1'b1}}};

  typedef logic [2:0][CW-1:0]   vec3_t;
  typedef logic [2:0][RM_W-1:0] rmag3_t;

  // payload ahead of and through the square root
  typedef struct packed {
    logic  kind;
    vec3_t vec;
    vec3_t a;
    vec3_t mag;
    logic  unit;
  } front_t;

  // payload through the dividers
  typedef struct packed {
    logic  kind;
    vec3_t vec;
    vec3_t a;
    logic  skip;
  } mid_t;

  // payload through the projection back end
  typedef struct packed {
    logic  kind;
    vec3_t u;
    logic  skip;
  } back_t;

endpackage

`default_nettype wire

// ===== rtl/vnp_isqrt.sv =====
// ----------------------------------------------------------------------------
// vnp_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vnp_isqrt (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [vnp_pkg::SQ_W-1:0]  s,
  output logic      [vnp_pkg::CW-1:0]    root
);

  localparam int CW   = vnp_pkg::CW;
  localparam int SQ_W = vnp_pkg::SQ_W;

  logic [CW+1:0]   rem  [CW];
  logic [CW-1:0]   rt   [CW];
  logic [SQ_W-1:0] bits [CW];

  for (genvar j = 0; j < CW; j++) begin : g_stage
    logic [CW+1:0]   rem_in;
    logic [CW-1:0]   rt_in;
    logic [SQ_W-1:0] bits_in;
    logic [CW+3:0]   rem4;
    logic [CW+3:0]   trial;
    logic [CW+3:0]   diff;
    logic            ge;

    // operands from the previous stage
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign rt_in   = '0;
      assign bits_in = s;
    end else begin : g_next
      assign rem_in  = rem[j-1];
      assign rt_in   = rt[j-1];
      assign bits_in = bits[j-1];
    end

    // bring down two bits, try 4*root+1
    assign rem4  = {rem_in, bits_in[SQ_W-1 -: 2]};
    assign trial = {2'b00, rt_in, 2'b01};
    assign diff  = rem4 - trial;
    assign ge    = (rem4 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]  <= ge ? diff[CW+1:0] : rem4[CW+1:0];
        rt[j]   <= {rt_in[CW-2:0], ge};
        bits[j] <= bits_in << 2;
      end
    end
  end

  assign root = rt[CW-1];

endmodule

`default_nettype wire

// ===== rtl/vnp_div.sv =====
// ----------------------------------------------------------------------------
// vnp_div
// Pipelined restoring divider lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vnp_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [vnp_pkg::NUM_W-1:0]  num,
  input  wire logic [vnp_pkg::CW-1:0]     den,
  output logic      [vnp_pkg::QW-1:0]     quo
);

  localparam int CW    = vnp_pkg::CW;
  localparam int QW    = vnp_pkg::QW;
  localparam int NUM_W = vnp_pkg::NUM_W;

  logic [CW-1:0] rem  [QW];
  logic [QW-1:0] low  [QW];
  logic [QW-1:0] q    [QW];
  logic [CW-1:0] dv   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [CW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [CW-1:0] dv_in;
    logic [CW:0]   r2;
    logic [CW:0]   diff;
    logic          ge;

    // upper numerator bits start as the partial remainder
    if (k == 0) begin : g_first
      assign rem_in = CW'(num[NUM_W-1:QW]);
      assign low_in = num[QW-1:0];
      assign q_in   = '0;
      assign dv_in  = den;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign low_in = low[k-1];
      assign q_in   = q[k-1];
      assign dv_in  = dv[k-1];
    end

    // shift in next bit, subtract when it fits
    assign r2   = {rem_in, low_in[QW-1]};
    assign diff = r2 - {1'b0, dv_in};
    assign ge   = (r2 >= {1'b0, dv_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[CW-1:0] : r2[CW-1:0];
        low[k] <= low_in << 1;
        q[k]   <= {q_in[QW-2:0], ge};
        dv[k]  <= dv_in;
      end
    end
  end

  assign quo = q[QW-1];

endmodule

`default_nettype wire

// ===== rtl/vnp_proj.sv =====
// ----------------------------------------------------------------------------
// vnp_proj
// Projection back end: dot product, rescale, scale of the unit direction
// and final rescale, as sign and magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vnp_proj (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire vnp_pkg::vec3_t   u,
  input  wire vnp_pkg::vec3_t   v,
  output vnp_pkg::rmag3_t       mag,
  output logic [2:0]            neg
);

  localparam int CW      = vnp_pkg::CW;
  localparam int SQ_W    = vnp_pkg::SQ_W;
  localparam int ACC_W   = vnp_pkg::ACC_W;
  localparam int RM_W    = vnp_pkg::RM_W;
  localparam int LO_W    = vnp_pkg::LO_W;
  localparam int HI_KEEP = vnp_pkg::HI_KEEP;
  localparam int FB      = vnp_pkg::FRAC_BITS;
  localparam int HI_W    = RM_W + 1 - LO_W;

  logic signed [SQ_W-1:0]  prod [3];
  logic        [ACC_W-1:0] dot;
  logic        [ACC_W-1:0] dabs;
  logic        [ACC_W-1:0] dsum;
  logic                    dneg_a;
  logic                    dneg_b;
  logic        [RM_W-1:0]  dmag;
  logic        [RM_W:0]    dext;
  logic        [RM_W:0]    dqs;
  vnp_pkg::vec3_t          u_d [5];

  // scalar path: sum of products, magnitude, round, signed scale
  assign dsum = dabs + vnp_pkg::ROUND_HALF;
  assign dext = {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (en) begin
      dot    <= ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]);
      dneg_a <= dot[ACC_W-1];
      dabs   <= dot[ACC_W-1] ? -dot : dot;
      dneg_b <= dneg_a;
      dmag   <= dsum[ACC_W-1:FB];
      dqs    <= dneg_b ? -dext : dext;
      u_d[0] <= u;
      for (int k = 1; k < 5; k++) begin
        u_d[k] <= u_d[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [CW+LO_W:0]   plo;
    logic        [HI_KEEP-1:0] phi;
    logic signed [CW+HI_W-1:0] phi_full;
    logic        [ACC_W-1:0]   r;
    logic        [ACC_W-1:0]   rabs;
    logic        [ACC_W-1:0]   rsum;
    logic                      rneg;

    // upper partial product, only the bits below 2^ACC_W matter
    assign phi_full = $signed(u_d[4][i]) * $signed(dqs[RM_W:LO_W]);
    assign rsum     = rabs + vnp_pkg::ROUND_HALF;

    always_ff @(posedge clk) begin
      if (en) begin
        prod[i] <= $signed(u[i]) * $signed(v[i]);
        plo     <= $signed(u_d[4][i]) * $signed({1'b0, dqs[LO_W-1:0]});
        phi     <= phi_full[HI_KEEP-1:0];
        r       <= ACC_W'(plo) + {phi, {LO_W{1'b0}}};
        rneg    <= r[ACC_W-1];
        rabs    <= r[ACC_W-1] ? -r : r;
        mag[i]  <= rsum[ACC_W-1:FB];
        neg[i]  <= rneg;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vector3_normalize_project_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize_project_unit
// Normalises a signed 3D vector, or projects it onto a normalised direction.
// Throughput: one beat per cycle while no result beat is held; the 32-stage
// square root, the 17-stage dividers and the multipliers are fully pipelined.
// Reset clears all valid bits and sets epsilon to 7; payload is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vector3_normalize_project_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [vnp_pkg::EPS_W-1:0]        cfg_epsilon,
  // input beats
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             kind,
  input  wire logic signed [vnp_pkg::CW-1:0]    vec_x,
  input  wire logic signed [vnp_pkg::CW-1:0]    vec_y,
  input  wire logic signed [vnp_pkg::CW-1:0]    vec_z,
  input  wire logic signed [vnp_pkg::CW-1:0]    dir_x,
  input  wire logic signed [vnp_pkg::CW-1:0]    dir_y,
  input  wire logic signed [vnp_pkg::CW-1:0]    dir_z,
  // result beats
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [vnp_pkg::CW-1:0]         res_x,
  output logic signed [vnp_pkg::CW-1:0]         res_y,
  output logic signed [vnp_pkg::CW-1:0]         res_z,
  output logic                                  scaling_skipped
);

  localparam int CW       = vnp_pkg::CW;
  localparam int FB       = vnp_pkg::FRAC_BITS;
  localparam int SQ_W     = vnp_pkg::SQ_W;
  localparam int NUM_W    = vnp_pkg::NUM_W;
  localparam int QW       = vnp_pkg::QW;
  localparam int PROJ_LAT = vnp_pkg::PROJ_LAT;
  localparam int LATENCY  = vnp_pkg::LATENCY;

  logic                       en;
  logic [LATENCY-1:0]         vld;
  logic [vnp_pkg::EPS_W-1:0]  epsilon;

  logic                       kind0;
  vnp_pkg::vec3_t             vec0;
  vnp_pkg::vec3_t             dir0;
  vnp_pkg::vec3_t             a_c;
  vnp_pkg::front_t            f1;
  vnp_pkg::front_t            f2;
  vnp_pkg::front_t            f3;
  vnp_pkg::front_t            f4;
  logic [2:0][SQ_W-1:0]       sq;
  logic [SQ_W-1:0]            s3;
  logic [SQ_W-1:0]            s4;
  logic [SQ_W-1:0]            diff_c;
  logic                       unit_c;

  vnp_pkg::front_t            sqd [CW];
  logic [CW-1:0]              root;
  logic                       skip_c;
  logic [2:0][NUM_W-1:0]      num;
  logic [CW-1:0]              den;
  vnp_pkg::mid_t              m5;

  vnp_pkg::mid_t              dvd [QW];
  logic [2:0][QW-1:0]         quo;
  vnp_pkg::vec3_t             u_c;
  vnp_pkg::back_t             b6;
  vnp_pkg::vec3_t             vec6;

  vnp_pkg::back_t             pjd [PROJ_LAT];
  vnp_pkg::rmag3_t            pmag;
  logic [2:0]                 pneg;
  vnp_pkg::vec3_t             sat_c;
  vnp_pkg::vec3_t             res;
  logic                       skipped;

  // whole pipeline moves unless a result beat is held
  assign en        = ~(out_valid & out_stall);
  assign in_stall  = out_valid & out_stall;
  assign out_valid = vld[LATENCY-1];
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= vnp_pkg::EPS_RESET;
    end else if (cfg_valid) begin
      epsilon <= cfg_epsilon;
    end
  end

  // valid bits travel with the beats
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], in_valid};
    end
  end

  // operand select and near-unit test
  assign a_c    = kind0 ? dir0 : vec0;
  assign diff_c = (s3 > vnp_pkg::ONE_SQ) ? (s3 - vnp_pkg::ONE_SQ) : (vnp_pkg::ONE_SQ - s3);
  assign unit_c = (diff_c <= (SQ_W'(epsilon) << FB));

  // front: capture, magnitude, squares, sum, near-unit
  always_ff @(posedge clk) begin
    if (en) begin
      kind0   <= kind;
      vec0    <= {vec_z, vec_y, vec_x};
      dir0    <= {dir_z, dir_y, dir_x};
      f1.kind <= kind0;
      f1.vec  <= vec0;
      f1.a    <= a_c;
      f1.unit <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        f1.mag[i] <= a_c[i][CW-1] ? -a_c[i] : a_c[i];
        sq[i]     <= f1.mag[i] * f1.mag[i];
      end
      f2      <= f1;
      s3      <= sq[0] + sq[1] + sq[2];
      f3      <= f2;
      s4      <= s3;
      f4.kind <= f3.kind;
      f4.vec  <= f3.vec;
      f4.a    <= f3.a;
      f4.mag  <= f3.mag;
      f4.unit <= unit_c;
    end
  end

  vnp_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .s    (s4),
    .root (root)
  );

  // side data alongside the square root
  always_ff @(posedge clk) begin
    if (en) begin
      sqd[0] <= f4;
      for (int k = 1; k < CW; k++) begin
        sqd[k] <= sqd[k-1];
      end
    end
  end

  // near-zero test and divider numerators
  assign skip_c = sqd[CW-1].unit | (root <= CW'(epsilon));

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num[i] <= {sqd[CW-1].mag[i], {FB{1'b0}}} + NUM_W'(root[CW-1:1]);
      end
      den     <= root;
      m5.kind <= sqd[CW-1].kind;
      m5.vec  <= sqd[CW-1].vec;
      m5.a    <= sqd[CW-1].a;
      m5.skip <= skip_c;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    vnp_div u_div (
      .clk (clk),
      .en  (en),
      .num (num[i]),
      .den (den),
      .quo (quo[i])
    );
  end

  // side data alongside the dividers, then signed unit components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dvd[QW-1].skip) begin
        u_c[i] = dvd[QW-1].a[i];
      end else if (dvd[QW-1].a[i][CW-1]) begin
        u_c[i] = -CW'(quo[i]);
      end else begin
        u_c[i] = CW'(quo[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd[0] <= m5;
      for (int k = 1; k < QW; k++) begin
        dvd[k] <= dvd[k-1];
      end
      b6.kind <= dvd[QW-1].kind;
      b6.u    <= u_c;
      b6.skip <= dvd[QW-1].skip;
      vec6    <= dvd[QW-1].vec;
    end
  end

  vnp_proj u_proj (
    .clk (clk),
    .en  (en),
    .u   (b6.u),
    .v   (vec6),
    .mag (pmag),
    .neg (pneg)
  );

  // side data alongside the projection
  always_ff @(posedge clk) begin
    if (en) begin
      pjd[0] <= b6;
      for (int k = 1; k < PROJ_LAT; k++) begin
        pjd[k] <= pjd[k-1];
      end
    end
  end

  // saturate to the component range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pneg[i]) begin
        sat_c[i] = (pmag[i] > vnp_pkg::NEG_LIM) ? vnp_pkg::COMP_MIN : -pmag[i][CW-1:0];
      end else begin
        sat_c[i] = (pmag[i] > vnp_pkg::POS_LIM) ? vnp_pkg::COMP_MAX : pmag[i][CW-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      res     <= pjd[PROJ_LAT-1].kind ? sat_c : pjd[PROJ_LAT-1].u;
      skipped <= pjd[PROJ_LAT-1].skip;
    end
  end

  assign res_x           = res[0];
  assign res_y           = res[1];
  assign res_z           = res[2];
  assign scaling_skipped = skipped;

endmodule

`default_nettype wire
